>>> design/crd_pkg.sv
// ----------------------------------------------------------------------------
// crd_pkg
// Shared types, codes and helpers for the controller response deframer.
// ----------------------------------------------------------------------------
package crd_pkg;

  localparam int LINE_COUNT_BITS = 8;
  localparam int CHAR_W          = 8;
  localparam int REPLY_W         = 4;
  localparam int FAIL_W          = 3;
  localparam int LIMIT_W         = 3;
  localparam int OP_W            = 2;
  localparam int KIND_W          = 3;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX      = {LINE_COUNT_BITS{1'b1}};
  localparam logic [FAIL_W-1:0]          FAIL_MAX      = {FAIL_W{1'b1}};
  localparam logic [LIMIT_W-1:0]         LIMIT_RESET   = LIMIT_W'(3);
  localparam logic [CHAR_W-1:0]          LF_CHAR       = 8'h0A;
  localparam logic [CHAR_W-1:0]          CR_CHAR       = 8'h0D;

  // register index of retry_limit
  localparam logic [CFG_ADDR_W-3:0]      REG_RETRY_LIMIT = '0;

  typedef enum logic [OP_W-1:0] {
    OP_START   = 2'd0,
    OP_CHAR    = 2'd1,
    OP_FAIL    = 2'd2,
    OP_CMD_ERR = 2'd3
  } crd_op_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_BODY    = 2'd2,
    PH_TRAILER = 2'd3
  } crd_phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BODY    = 3'd0,
    KIND_END     = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_TIMEOUT = 3'd3,
    KIND_CMD_ERR = 3'd4
  } crd_kind_t;

  typedef struct packed {
    crd_phase_t                 phase;
    logic [LINE_COUNT_BITS-1:0] header_lines;
    logic [LINE_COUNT_BITS-1:0] trailer_lines;
    logic [FAIL_W-1:0]          failed_attempts;
    logic [REPLY_W-1:0]         replies_left;
  } crd_state_t;

  typedef struct packed {
    logic              valid;
    crd_kind_t         kind;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } crd_result_t;

  function automatic logic [LINE_COUNT_BITS-1:0] line_inc(
    input logic [LINE_COUNT_BITS-1:0] v
  );
    line_inc = (v == LINE_MAX) ? v : v + 1'b1;
  endfunction

endpackage

>>> design/crd_cfg.sv
// ----------------------------------------------------------------------------
// crd_cfg
// APB-style register port holding the retry limit.
// ----------------------------------------------------------------------------
module crd_cfg
  import crd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [LIMIT_W-1:0]    retry_limit
);

  logic [LIMIT_W-1:0] retry_limit_r;
  logic [LIMIT_W-1:0] retry_limit_nxt;
  logic               hit_limit;
  logic               wr_en;

  assign hit_limit = (paddr[CFG_ADDR_W-1:2] == REG_RETRY_LIMIT);
  assign wr_en     = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    retry_limit_nxt = retry_limit_r;
    if (wr_en && hit_limit) begin
      retry_limit_nxt = pwdata[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= LIMIT_RESET;
    end else begin
      retry_limit_r <= retry_limit_nxt;
    end
  end

  assign prdata      = hit_limit ? CFG_DATA_W'(retry_limit_r) : '0;
  assign retry_limit = retry_limit_r;

endmodule

>>> design/crd_step.sv
// ----------------------------------------------------------------------------
// crd_step
// Next-state and result logic for one request item of the deframer.
// ----------------------------------------------------------------------------
module crd_step
  import crd_pkg::*;
(
  input  crd_op_t              op,
  input  logic [CHAR_W-1:0]    ch,
  input  logic [REPLY_W-1:0]   reply_count,
  input  logic [LIMIT_W-1:0]   retry_limit,
  input  crd_state_t           cur,
  output crd_state_t           nxt,
  output crd_result_t          res
);

  logic                       eol;
  logic [FAIL_W-1:0]          fail_inc;
  logic [LINE_COUNT_BITS-1:0] trailer_inc;
  logic [REPLY_W-1:0]         replies_dec;

  assign eol         = (ch == LF_CHAR) || (ch == CR_CHAR);
  assign fail_inc    = (cur.failed_attempts == FAIL_MAX) ? cur.failed_attempts
                                                         : cur.failed_attempts + 1'b1;
  assign trailer_inc = line_inc(cur.trailer_lines);
  assign replies_dec = (cur.replies_left != '0) ? cur.replies_left - 1'b1
                                                : cur.replies_left;

  always_comb begin
    nxt       = cur;
    res.valid = 1'b0;
    res.kind  = KIND_BODY;
    res.ch    = '0;
    res.last  = 1'b0;

    if (op == OP_START) begin
      nxt.replies_left    = reply_count;
      nxt.header_lines    = '0;
      nxt.trailer_lines   = '0;
      nxt.failed_attempts = '0;
      if (reply_count == '0) begin
        nxt.phase = PH_IDLE;
        res.valid = 1'b1;
        res.kind  = KIND_DONE;
        res.last  = 1'b1;
      end else begin
        nxt.phase = PH_HEADER;
      end
    end else if (cur.phase != PH_IDLE) begin
      unique case (op)
        OP_CMD_ERR: begin
          nxt.phase = PH_IDLE;
          res.valid = 1'b1;
          res.kind  = KIND_CMD_ERR;
          res.last  = 1'b1;
        end
        OP_FAIL: begin
          nxt.failed_attempts = fail_inc;
          if (fail_inc >= retry_limit) begin
            nxt.phase = PH_IDLE;
            res.valid = 1'b1;
            res.kind  = KIND_TIMEOUT;
            res.last  = 1'b1;
          end
        end
        OP_CHAR: begin
          nxt.failed_attempts = FAIL_W'(1);
          unique case (cur.phase)
            PH_HEADER: begin
              if (eol) begin
                nxt.header_lines = line_inc(cur.header_lines);
              end else begin
                nxt.phase = PH_BODY;
                res.valid = 1'b1;
                res.kind  = KIND_BODY;
                res.ch    = ch;
              end
            end
            PH_BODY: begin
              if (eol) begin
                nxt.trailer_lines = trailer_inc;
                nxt.phase         = PH_TRAILER;
              end else begin
                res.valid = 1'b1;
                res.kind  = KIND_BODY;
                res.ch    = ch;
              end
            end
            PH_TRAILER: begin
              nxt.trailer_lines = trailer_inc;
              if (trailer_inc >= cur.header_lines) begin
                // reply complete: either next reply or end of request
                nxt.replies_left = replies_dec;
                res.valid        = 1'b1;
                if (replies_dec == '0) begin
                  nxt.phase = PH_IDLE;
                  res.kind  = KIND_DONE;
                  res.last  = 1'b1;
                end else begin
                  nxt.phase           = PH_HEADER;
                  nxt.header_lines    = '0;
                  nxt.trailer_lines   = '0;
                  nxt.failed_attempts = '0;
                  res.kind            = KIND_END;
                end
              end
            end
            default: begin
              nxt = cur;
            end
          endcase
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

endmodule

>>> design/controller_response_deframer.sv
// ----------------------------------------------------------------------------
// controller_response_deframer
// Splits a motor controller's reply stream into body characters,
// reply-end marks and request completion / timeout / error results.
// ----------------------------------------------------------------------------
// path: a request passes from the input register through the combinational
//   state update into the result register; out_valid rises only for a valid result
// throughput: one request per cycle while out_stall does not hold the result
//   register; the state update between the two registers is combinational
// reset: retry limit 3, phase idle, all counters zero, both registers empty
module controller_response_deframer
  import crd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_op,
  input  logic [CHAR_W-1:0]     in_char,
  input  logic [REPLY_W-1:0]    in_reply_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KIND_W-1:0]     out_kind,
  output logic [CHAR_W-1:0]     out_char,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [LIMIT_W-1:0] retry_limit;

  logic               stage_valid_r;
  logic               stage_valid_nxt;
  crd_op_t            stage_op_r;
  logic [CHAR_W-1:0]  stage_char_r;
  logic [REPLY_W-1:0] stage_count_r;

  crd_state_t         state_r;
  crd_state_t         state_nxt;
  crd_state_t         step_state;
  crd_result_t        step_res;

  logic               out_valid_r;
  logic               out_valid_nxt;
  crd_kind_t          out_kind_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;

  logic               advance;
  logic               load_in;

  crd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .retry_limit (retry_limit)
  );

  crd_step u_step (
    .op          (stage_op_r),
    .ch          (stage_char_r),
    .reply_count (stage_count_r),
    .retry_limit (retry_limit),
    .cur         (state_r),
    .nxt         (step_state),
    .res         (step_res)
  );

  // the input register moves on whenever the result register is free or drains
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = stage_valid_r && !advance;
  assign load_in  = in_valid && !in_stall;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (!in_stall) begin
      stage_valid_nxt = in_valid;
    end
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = stage_valid_r && step_res.valid;
      if (stage_valid_r) begin
        state_nxt = step_state;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r         <= 1'b0;
      out_valid_r           <= 1'b0;
      state_r.phase           <= PH_IDLE;
      state_r.header_lines    <= '0;
      state_r.trailer_lines   <= '0;
      state_r.failed_attempts <= '0;
      state_r.replies_left    <= '0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      state_r       <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      stage_op_r    <= crd_op_t'(in_op);
      stage_char_r  <= in_char;
      stage_count_r <= in_reply_count;
    end
    if (advance && stage_valid_r) begin
      out_kind_r <= step_res.kind;
      out_char_r <= step_res.ch;
      out_last_r <= step_res.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  // a final result always leaves the deframer idle
  a_last_goes_idle : assert property (@(posedge clk) disable iff (!rst_n)
    advance && stage_valid_r && step_res.valid && step_res.last
      |=> state_r.phase == PH_IDLE)
    else $error("final result did not return to idle");

  // only done, timeout and command error close a request
  a_last_kind : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (out_kind_r == KIND_DONE) ||
      (out_kind_r == KIND_TIMEOUT) || (out_kind_r == KIND_CMD_ERR))
    else $error("last flag on a non-final result kind");

  // character field is zero except on body characters
  a_char_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind_r != KIND_BODY) |-> out_char == '0)
    else $error("non-body result carries a character");

  // the input side stalls only while a request is held waiting
  a_stall_held : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stage_valid_r && out_valid_r)
    else $error("input stalled with nothing waiting");

endmodule
